>>> rtl/pid_temperature_profile_controller_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef PID_TEMPERATURE_PROFILE_CONTROLLER_UNIT_DEFINES_SVH
`define PID_TEMPERATURE_PROFILE_CONTROLLER_UNIT_DEFINES_SVH

// Same-cycle implication under active-low reset.
`define PTPC_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication under active-low reset.
`define PTPC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/ptpc_pkg.sv
`default_nettype none
package ptpc_pkg;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_GAIN_P   = 3'd0,
        CFG_GAIN_I   = 3'd1,
        CFG_GAIN_D   = 3'd2,
        CFG_TARGET   = 3'd3,
        CFG_PERIOD   = 3'd4,
        CFG_HEAT     = 3'd5,
        CFG_HOLD     = 3'd6,
        CFG_COOL     = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_HEAT = 2'd0,
        PH_HOLD = 2'd1,
        PH_COOL = 2'd2,
        PH_OFF  = 2'd3
    } t_phase;

    typedef enum logic [4:0] {
        ST_IDLE, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_DW, ST_M6, ST_M7,
        ST_CL, ST_M8, ST_DM_S, ST_M9, ST_DR_S, ST_DR_W, ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MS_ERR_DT, MS_P, MS_ILO, MS_IHI, MS_D, MS_MAP, MS_RAMP
    } t_mul_sel;

    typedef enum logic [2:0] {
        ACC_NONE, ACC_SET8, ACC_ADD, ACC_ADD24, ACC_ADD8
    } t_acc_op;

    typedef enum logic [1:0] {
        DV_DERIV, DV_RAMP
    } t_div_sel;

    typedef struct packed {
        logic     load;
        t_mul_sel mul_sel;
        logic     int_upd;
        logic     prev_upd;
        t_acc_op  acc_op;
        logic     div_start;
        t_div_sel div_sel;
        logic     deriv_ld;
        logic     y_ld;
        logic     drive_ld;
        logic     sp_ld;
        logic     out_ld;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic cooling;
        logic out_free;
    } t_sts;

    // Register reset values
    localparam logic [15:0] C_RST_GAIN_P = 16'd2458;
    localparam logic [15:0] C_RST_GAIN_I = 16'd5120;
    localparam logic [15:0] C_RST_GAIN_D = 16'd1393;
    localparam logic [15:0] C_RST_TARGET = 16'd7424;
    localparam logic [15:0] C_RST_PERIOD = 16'd333;
    localparam logic [15:0] C_RST_HEAT   = 16'd100;
    localparam logic [15:0] C_RST_HOLD   = 16'd20;
    localparam logic [15:0] C_RST_COOL   = 16'd100;

    // Clamp limits, +-500 with 24 fraction bits
    localparam logic signed [63:0] C_LIM_HI = 64'sd8388608000;
    localparam logic signed [63:0] C_LIM_LO = -64'sd8388608000;
    localparam logic signed [63:0] C_ROUND  = 64'sd16777215;
    localparam logic signed [10:0] C_OFFSET = 11'sd500;
    // y*255/1000 = y*51/200, taken as (y * 51 * ceil(2^24/200)) >> 24, exact for y <= 1000
    localparam logic signed [26:0] C_MAP_SCALE = 27'sd4278237;

    localparam logic signed [47:0] C_INT_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] C_INT_MIN = {1'b1, {47{1'b0}}};

    // Divider: one quotient bit per cycle
    localparam int C_DIV_BITS  = 32;
    localparam int C_DIV_CNT_W = $clog2(C_DIV_BITS);

endpackage
`default_nettype wire

>>> rtl/ptpc_div.sv
`default_nettype none
module ptpc_div
    import ptpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_dividend,
    input  wire logic        [15:0] i_divisor,
    output logic                    o_done,
    output logic signed [32:0]      o_quotient
);

    logic                   r_busy;
    logic                   r_done;
    logic [C_DIV_CNT_W-1:0] r_cnt;
    logic                   r_neg;
    logic [31:0]            r_q;
    logic [15:0]            r_rem;
    logic [15:0]            r_dvs;
    logic [32:0]            mag;
    logic [16:0]            rem_sh;
    logic [16:0]            rem_sub;
    logic                   qbit;

    // Take the magnitude of the dividend
    always_comb begin
        mag = i_dividend[32] ? 33'(-i_dividend) : 33'(i_dividend);
    end

    // One restoring step
    always_comb begin
        rem_sh  = {r_rem, r_q[31]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        qbit    = (rem_sh >= {1'b0, r_dvs});
    end

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == C_DIV_CNT_W'(C_DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift quotient in, keep partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[32];
            r_q   <= mag[31:0];
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[30:0], qbit};
            r_rem <= qbit ? rem_sub[15:0] : rem_sh[15:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

endmodule
`default_nettype wire

>>> rtl/ptpc_ctrl.sv
`default_nettype none
module ptpc_ctrl
    import ptpc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_M1;
            ST_M1:   n_state = ST_M2;
            ST_M2:   n_state = ST_M3;
            ST_M3:   n_state = ST_M4;
            ST_M4:   n_state = ST_M5;
            ST_M5:   n_state = ST_DW;
            ST_DW:   if (i_sts.div_done) n_state = ST_M6;
            ST_M6:   n_state = ST_M7;
            ST_M7:   n_state = ST_CL;
            ST_CL:   n_state = ST_M8;
            ST_M8:   n_state = ST_DM_S;
            ST_DM_S: n_state = i_sts.cooling ? ST_M9 : ST_OUT;
            ST_M9:   n_state = ST_DR_S;
            ST_DR_S: n_state = ST_DR_W;
            ST_DR_W: if (i_sts.div_done) n_state = ST_OUT;
            ST_OUT:  if (i_sts.out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MS_ERR_DT;
        o_cmd.acc_op  = ACC_NONE;
        o_cmd.div_sel = DV_DERIV;
        o_in_ready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_M1: o_cmd.mul_sel = MS_ERR_DT;
            ST_M2: begin
                o_cmd.int_upd   = 1'b1;
                o_cmd.mul_sel   = MS_P;
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DV_DERIV;
            end
            ST_M3: begin
                o_cmd.acc_op   = ACC_SET8;
                o_cmd.mul_sel  = MS_ILO;
                o_cmd.prev_upd = 1'b1;
            end
            ST_M4: begin
                o_cmd.acc_op  = ACC_ADD;
                o_cmd.mul_sel = MS_IHI;
            end
            ST_M5: o_cmd.acc_op = ACC_ADD24;
            ST_DW: o_cmd.deriv_ld = i_sts.div_done;
            ST_M6: o_cmd.mul_sel = MS_D;
            ST_M7: o_cmd.acc_op = ACC_ADD8;
            ST_CL: o_cmd.y_ld = 1'b1;
            ST_M8: o_cmd.mul_sel = MS_MAP;
            ST_DM_S: o_cmd.drive_ld = 1'b1;
            ST_M9: o_cmd.mul_sel = MS_RAMP;
            ST_DR_S: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DV_RAMP;
            end
            ST_DR_W: o_cmd.sp_ld = i_sts.div_done;
            ST_OUT:  o_cmd.out_ld = i_sts.out_free;
            default: o_cmd.load = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/ptpc_dp.sv
`default_nettype none
module ptpc_dp
    import ptpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic        [2:0]  i_cfg_index,
    input  wire logic        [15:0] i_cfg_data,
    input  wire logic signed [15:0] i_measured_temp,
    input  wire logic               i_sensor_valid,
    input  wire logic        [31:0] i_elapsed_seconds,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic             [7:0]  o_drive_level,
    output logic             [1:0]  o_phase,
    output logic             [17:0] o_remaining_seconds
);

    // Configuration
    logic signed [15:0] r_gain_p, r_gain_i, r_gain_d;
    logic        [15:0] r_period, r_heat, r_hold, r_cool;

    // Controller state
    logic signed [47:0] r_int;
    logic signed [16:0] r_prev;
    logic signed [15:0] r_sp;

    // Per-item work registers
    logic signed [15:0] r_meas;
    logic signed [16:0] r_err;
    t_phase             r_phase;
    logic        [17:0] r_rem;
    logic signed [43:0] r_prod;
    logic signed [63:0] r_acc;
    logic signed [25:0] r_deriv;
    logic        [9:0]  r_y;
    logic        [7:0]  r_drive;
    logic               r_out_valid;

    logic signed [15:0] meas_in;
    logic        [16:0] b1, b2;
    logic        [17:0] b3;
    t_phase             phase_in;
    logic        [17:0] rem_in;
    logic signed [16:0] m_a;
    logic signed [26:0] m_b;
    logic signed [43:0] m_p;
    logic signed [48:0] int_sum;
    logic signed [17:0] diff;
    logic signed [32:0] dv_num;
    logic        [15:0] dv_den;
    logic               dv_done;
    logic signed [32:0] dv_q;
    logic signed [63:0] sat;
    logic signed [63:0] sat_adj;
    logic signed [10:0] y_wide;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p <= C_RST_GAIN_P;
            r_gain_i <= C_RST_GAIN_I;
            r_gain_d <= C_RST_GAIN_D;
            r_period <= C_RST_PERIOD;
            r_heat   <= C_RST_HEAT;
            r_hold   <= C_RST_HOLD;
            r_cool   <= C_RST_COOL;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P: r_gain_p <= i_cfg_data;
                CFG_GAIN_I: r_gain_i <= i_cfg_data;
                CFG_GAIN_D: r_gain_d <= i_cfg_data;
                CFG_PERIOD: r_period <= i_cfg_data;
                CFG_HEAT:   r_heat   <= i_cfg_data;
                CFG_HOLD:   r_hold   <= i_cfg_data;
                CFG_COOL:   r_cool   <= i_cfg_data;
                default:    r_period <= r_period;
            endcase
        end
    end

    // Phase selection from elapsed time
    always_comb begin
        meas_in = i_sensor_valid ? i_measured_temp : 16'sd0;
        b1 = {1'b0, r_heat};
        b2 = {1'b0, r_heat} + {1'b0, r_hold};
        b3 = {1'b0, b2} + {2'b0, r_cool};
        if (i_elapsed_seconds <= {15'b0, b1}) begin
            phase_in = PH_HEAT;
            rem_in   = {1'b0, b1} - i_elapsed_seconds[17:0];
        end else if (i_elapsed_seconds <= {15'b0, b2}) begin
            phase_in = PH_HOLD;
            rem_in   = {1'b0, b2} - i_elapsed_seconds[17:0];
        end else if (i_elapsed_seconds <= {14'b0, b3}) begin
            phase_in = PH_COOL;
            rem_in   = b3 - i_elapsed_seconds[17:0];
        end else begin
            phase_in = PH_OFF;
            rem_in   = '0;
        end
    end

    // Shared multiplier operand select
    always_comb begin
        case (i_cmd.mul_sel)
            MS_ERR_DT: begin
                m_a = r_err;
                m_b = {11'b0, r_period};
            end
            MS_P: begin
                m_a = {r_gain_p[15], r_gain_p};
                m_b = {{10{r_err[16]}}, r_err};
            end
            MS_ILO: begin
                m_a = {r_gain_i[15], r_gain_i};
                m_b = {3'b0, r_int[23:0]};
            end
            MS_IHI: begin
                m_a = {r_gain_i[15], r_gain_i};
                m_b = {{3{r_int[47]}}, r_int[47:24]};
            end
            MS_D: begin
                m_a = {r_gain_d[15], r_gain_d};
                m_b = {r_deriv[25], r_deriv};
            end
            MS_MAP: begin
                m_a = {7'b0, r_y};
                m_b = C_MAP_SCALE;
            end
            MS_RAMP: begin
                m_a = {r_meas[15], r_meas};
                m_b = {9'b0, r_rem};
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
        m_p = m_a * m_b;
    end

    // Widened integral sum for the saturation check, difference for the derivative
    always_comb begin
        int_sum = {r_int[47], r_int} + {{5{r_prod[43]}}, r_prod};
        diff    = {r_err[16], r_err} - {r_prev[16], r_prev};
    end

    // Divider operand select
    always_comb begin
        case (i_cmd.div_sel)
            DV_DERIV: begin
                dv_num = {{7{diff[17]}}, diff, 8'b0};
                dv_den = r_period;
            end
            DV_RAMP: begin
                dv_num = r_prod[32:0];
                dv_den = r_cool;
            end
            default: begin
                dv_num = '0;
                dv_den = r_period;
            end
        endcase
    end

    ptpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dv_num),
        .i_divisor  (dv_den),
        .o_done     (dv_done),
        .o_quotient (dv_q)
    );

    // Clamp to +-500 and truncate toward zero, then offset
    always_comb begin
        if (r_acc > C_LIM_HI) begin
            sat = C_LIM_HI;
        end else if (r_acc < C_LIM_LO) begin
            sat = C_LIM_LO;
        end else begin
            sat = r_acc;
        end
        sat_adj = sat + (sat[63] ? C_ROUND : 64'sd0);
        y_wide  = {sat_adj[33], sat_adj[33:24]} + C_OFFSET;
    end

    // Controller state: integral, previous error, active setpoint
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int  <= '0;
            r_prev <= '0;
            r_sp   <= C_RST_TARGET;
        end else begin
            if (i_cmd.int_upd) begin
                if (r_err == 17'sd0) begin
                    r_int <= '0;
                end else if (int_sum[48] != int_sum[47]) begin
                    r_int <= int_sum[48] ? C_INT_MIN : C_INT_MAX;
                end else begin
                    r_int <= int_sum[47:0];
                end
            end
            if (i_cmd.prev_upd) r_prev <= r_err;
            if (i_cfg_we && t_cfg_idx'(i_cfg_index) == CFG_TARGET) begin
                r_sp <= i_cfg_data;
            end else if (i_cmd.sp_ld) begin
                r_sp <= dv_q[15:0];
            end
        end
    end

    // Per-item work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_meas  <= meas_in;
            r_err   <= {r_sp[15], r_sp} - {meas_in[15], meas_in};
            r_phase <= phase_in;
            r_rem   <= rem_in;
        end
        r_prod <= m_p;
        case (i_cmd.acc_op)
            ACC_SET8:  r_acc <= {{12{r_prod[43]}}, r_prod, 8'b0};
            ACC_ADD:   r_acc <= r_acc + {{20{r_prod[43]}}, r_prod};
            ACC_ADD24: r_acc <= r_acc + {r_prod[39:0], 24'b0};
            ACC_ADD8:  r_acc <= r_acc + {{12{r_prod[43]}}, r_prod, 8'b0};
            default:   r_acc <= r_acc;
        endcase
        if (i_cmd.deriv_ld) r_deriv <= (r_period == 16'd0) ? 26'sd0 : dv_q[25:0];
        if (i_cmd.y_ld)     r_y     <= y_wide[9:0];
        // Drive level is the reciprocal product shifted down by 24
        if (i_cmd.drive_ld) r_drive <= r_prod[31:24];
    end

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            o_drive_level       <= r_drive;
            o_phase             <= r_phase;
            o_remaining_seconds <= r_rem;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sts.div_done = dv_done;
    assign o_sts.cooling  = (r_phase == PH_COOL);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule
`default_nettype wire

>>> rtl/pid_temperature_profile_controller_unit.sv
// PID heater controller with a heat/hold/cool temperature profile, Q8.8 fixed point.
// Each input item (measured temperature, sensor valid flag, elapsed seconds) yields one
// result item (drive level 0..255, phase, seconds left in the phase). One item at a time
// is processed; the one-bit-per-cycle divider sets the time from accept to the result
// register: a 32-step division for the derivative and, only while cooling, a second one
// for the setpoint ramp. The other steps run on the shared 17x27 multiplier, which also
// maps the drive level by a reciprocal multiply. The input is ready again the cycle after
// the result is loaded, so a new item can be accepted even while the previous result
// waits to be taken. Configuration is written through a plain write port; the user must
// write it only while the block is idle, which the block itself does not enforce.
// Writing target_temp also reloads the active setpoint.
`default_nettype none
module pid_temperature_profile_controller_unit
    import ptpc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic        [2:0]  i_cfg_index,
    input  wire logic        [15:0] i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic signed [15:0] i_measured_temp,
    input  wire logic               i_sensor_valid,
    input  wire logic        [31:0] i_elapsed_seconds,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic             [7:0]  o_drive_level,
    output logic             [1:0]  o_phase,
    output logic             [17:0] o_remaining_seconds
);

    t_cmd cmd;
    t_sts sts;

    ptpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ptpc_dp u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_measured_temp     (i_measured_temp),
        .i_sensor_valid      (i_sensor_valid),
        .i_elapsed_seconds   (i_elapsed_seconds),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_drive_level       (o_drive_level),
        .o_phase             (o_phase),
        .o_remaining_seconds (o_remaining_seconds)
    );

endmodule
`default_nettype wire

>>> rtl/ptpc_checker.sv
`default_nettype none
`include "pid_temperature_profile_controller_unit_defines.svh"
module ptpc_checker
    import ptpc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_phase,
    input wire logic [17:0] o_remaining_seconds
);

    // A stalled result stays offered
    `PTPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // An accepted item keeps the block busy in the next cycle
    `PTPC_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // The off phase reports no remaining time
    `PTPC_ASSERT_NOW(a_off_no_rem, i_clk, i_rst_n, o_out_valid && o_phase == PH_OFF, o_remaining_seconds == 18'd0)

endmodule

bind pid_temperature_profile_controller_unit ptpc_checker u_ptpc_checker (.*);
`default_nettype wire
